@@ rtl/pbd_pkg.sv @@
// Shared widths, codes, constants and types of the pushbutton dimmer tracker.
`default_nettype none

package pbd_pkg;

    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 16;
    localparam int SPEED_W    = 20;
    localparam int THRESH_W   = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [SPEED_W-1:0]  DIM_SPEED_RESET = SPEED_W'(13107);
    localparam logic [THRESH_W-1:0] THRESH_RESET    = THRESH_W'(900);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam longint unsigned    MS_PER_S  = 1000;

    // Any product at or above this value moves the level by a full scale or more.
    localparam longint unsigned SAT_PRODUCT    = (longint'(LEVEL_MAX) + 1) * MS_PER_S;
    localparam int              EXCESS_KEEP_W  = $clog2(SAT_PRODUCT);
    localparam int              FULL_PROD_W    = SPEED_W + EXCESS_KEEP_W;

    // Reciprocal of one thousand, exact for every product below the saturation point.
    localparam int              RECIP_SHIFT = 36;
    localparam longint unsigned RECIP       = ((64'd1 << RECIP_SHIFT) + MS_PER_S - 1) / MS_PER_S;
    localparam int              RECIP_W     = $clog2(RECIP);
    localparam int              QPROD_W     = EXCESS_KEEP_W + RECIP_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_HELD    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_SPEED  = 2'd0,
        CFG_THRESH_ON  = 2'd1,
        CFG_THRESH_OFF = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SPEED_W-1:0]  dim_speed;
        logic [THRESH_W-1:0] thresh_on;
        logic [THRESH_W-1:0] thresh_off;
    } t_cfg;

    typedef struct packed {
        t_kind                    kind;
        logic                     lamp_on;
        logic                     dim_up;
        logic                     est_up;
        logic                     sat;
        logic [EXCESS_KEEP_W-1:0] prod;
    } t_mid;

endpackage

`default_nettype wire

@@ rtl/pbd_ifs.sv @@
// Handshake interfaces for the sample, result and configuration channels.
`default_nettype none

interface pbd_in_if import pbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              button_level;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output button_level, output time_ms, input ready);
    modport sink   (input valid, input button_level, input time_ms, output ready);
endinterface

interface pbd_out_if import pbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  report_kind;
    logic               lamp_on;
    logic               dim_up;
    logic [LEVEL_W-1:0] shown_level;

    modport source (output valid, output report_kind, output lamp_on, output dim_up,
                    output shown_level, input ready);
    modport sink   (input valid, input report_kind, input lamp_on, input dim_up,
                    input shown_level, output ready);
endinterface

interface pbd_cfg_if import pbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pbd_cfg_regs.sv @@
// Configuration registers: dimming speed and the two press thresholds.
`default_nettype none

module pbd_cfg_regs import pbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pbd_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_speed  <= DIM_SPEED_RESET;
            r_cfg.thresh_on  <= THRESH_RESET;
            r_cfg.thresh_off <= THRESH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DIM_SPEED:  r_cfg.dim_speed  <= i_cfg.data[SPEED_W-1:0];
                CFG_THRESH_ON:  r_cfg.thresh_on  <= i_cfg.data[THRESH_W-1:0];
                CFG_THRESH_OFF: r_cfg.thresh_off <= i_cfg.data[THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbd_ctrl.sv @@
// Sample register, press tracking state machine and excess-time product stage.
`default_nettype none

module pbd_ctrl import pbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pbd_in_if.sink    i_in,
    input  wire t_cfg i_cfg,
    input  wire logic i_mid_ready,
    output logic      o_mid_valid,
    output t_mid      o_mid
);

    logic              r_in_vld;
    logic              r_in_btn;
    logic [TIME_W-1:0] r_in_time;

    logic              r_is_on,   n_is_on;
    logic              r_dir_up,  n_dir_up;
    logic              r_last,    n_last;
    logic [TIME_W-1:0] r_pstart,  n_pstart;

    logic              r_mid_vld;
    t_mid              r_mid,     n_mid;

    logic                   adv;
    logic                   fall;
    logic                   rise;
    logic                   held;
    logic                   est_active;
    logic                   big;
    logic [TIME_W-1:0]      dur;
    logic [TIME_W-1:0]      thr;
    logic [TIME_W-1:0]      excess;
    logic [FULL_PROD_W-1:0] prod;

    assign adv         = r_in_vld && (!r_mid_vld || i_mid_ready);
    assign i_in.ready  = !r_in_vld || adv;
    assign o_mid_valid = r_mid_vld;
    assign o_mid       = r_mid;

    assign dur    = r_in_time - r_pstart;
    assign thr    = TIME_W'(r_is_on ? i_cfg.thresh_on : i_cfg.thresh_off);
    assign excess = dur - thr;
    assign fall   = !r_in_btn && r_last;
    assign rise   = r_in_btn && !r_last;
    assign held   = r_in_btn && r_last;
    assign big    = |excess[TIME_W-1:EXCESS_KEEP_W];
    assign prod   = FULL_PROD_W'(i_cfg.dim_speed) * FULL_PROD_W'(excess[EXCESS_KEEP_W-1:0]);

    // A press equal to the threshold leaves an excess of zero, so it never moves the level.
    assign est_active = (fall || held) && (dur >= thr);

    always_comb begin
        n_is_on  = r_is_on;
        n_dir_up = r_dir_up;
        n_pstart = r_pstart;
        n_last   = r_in_btn;
        n_mid    = '0;
        n_mid.kind = KIND_NONE;
        if (fall) begin
            n_mid.kind = KIND_RELEASE;
            if (!r_is_on) begin
                n_is_on  = 1'b1;
                n_dir_up = 1'b1;
            end else if (dur > thr) begin
                n_dir_up = !r_dir_up;
            end else begin
                n_is_on = 1'b0;
            end
        end else if (rise) begin
            n_pstart = r_in_time;
        end else if (r_in_btn) begin
            n_mid.kind = KIND_HELD;
        end
        n_mid.lamp_on = n_is_on;
        n_mid.dim_up  = n_dir_up;
        n_mid.est_up  = (fall && !r_is_on) ? 1'b1 : r_dir_up;
        n_mid.sat     = est_active &&
                        (((i_cfg.dim_speed != '0) && big) ||
                         (prod >= FULL_PROD_W'(SAT_PRODUCT)));
        n_mid.prod    = est_active ? prod[EXCESS_KEEP_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_is_on   <= 1'b0;
            r_dir_up  <= 1'b1;
            r_last    <= 1'b0;
            r_pstart  <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (!r_mid_vld || i_mid_ready) begin
                r_mid_vld <= r_in_vld;
            end
            if (adv) begin
                r_is_on  <= n_is_on;
                r_dir_up <= n_dir_up;
                r_last   <= n_last;
                r_pstart <= n_pstart;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_btn  <= i_in.button_level;
            r_in_time <= i_in.time_ms;
        end
        if (adv) begin
            r_mid <= n_mid;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbd_level.sv @@
// Divide by one thousand, saturating level update and result register.
`default_nettype none

module pbd_level import pbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_mid_valid,
    input  wire t_mid i_mid,
    output logic      o_mid_ready,
    pbd_out_if.source o_res
);

    logic [LEVEL_W-1:0] r_level;
    logic               r_out_vld;
    logic [KIND_W-1:0]  r_kind;
    logic               r_lamp_on;
    logic               r_dim_up;
    logic [LEVEL_W-1:0] r_shown;

    logic               take;
    logic [QPROD_W-1:0] qfull;
    logic [LEVEL_W-1:0] delta;
    logic [LEVEL_W:0]   sum;
    logic [LEVEL_W-1:0] est;
    logic [LEVEL_W-1:0] n_shown;

    assign o_mid_ready       = !r_out_vld || o_res.ready;
    assign take              = i_mid_valid && o_mid_ready;
    assign o_res.valid       = r_out_vld;
    assign o_res.report_kind = r_kind;
    assign o_res.lamp_on     = r_lamp_on;
    assign o_res.dim_up      = r_dim_up;
    assign o_res.shown_level = r_shown;

    assign qfull = QPROD_W'(i_mid.prod) * QPROD_W'(RECIP);
    assign delta = LEVEL_W'(qfull >> RECIP_SHIFT);
    assign sum   = {1'b0, r_level} + {1'b0, delta};

    always_comb begin
        if (i_mid.est_up) begin
            est = (i_mid.sat || sum[LEVEL_W]) ? LEVEL_MAX : sum[LEVEL_W-1:0];
        end else begin
            est = (i_mid.sat || (delta >= r_level)) ? '0 : r_level - delta;
        end
        case (i_mid.kind)
            KIND_HELD:    n_shown = est;
            KIND_RELEASE: n_shown = i_mid.lamp_on ? est : '0;
            default:      n_shown = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_level   <= '0;
        end else begin
            if (o_mid_ready) begin
                r_out_vld <= i_mid_valid;
            end
            if (take && (i_mid.kind == KIND_RELEASE)) begin
                r_level <= est;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind    <= i_mid.kind;
            r_lamp_on <= i_mid.lamp_on;
            r_dim_up  <= i_mid.dim_up;
            r_shown   <= n_shown;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pushbutton_dimmer_tracker.sv @@
// Top level of the pushbutton dimmer tracker.
//
//  Channel  Port    Direction  Payload
//  -------  ------  ---------  ------------------------------------------------
//  samples  i_in    in         button_level, time_ms
//  results  o_res   out        report_kind, lamp_on, dim_up, shown_level
//  config   i_cfg   in         index, data (dim_speed, thresh_on_ms, thresh_off_ms)
//
// A sample is accepted every cycle while results are taken; each gives one result.
// The stages are the sample register, the press state and excess product, and the
// divide and saturating level update; the last two stages hold one multiplier each.
// Reset returns the lamp to off, the level to zero, the direction to up and the
// registers to their defaults; it empties the pipeline.
// A stalled result holds its stage and the stages behind it fill before input stops.
`default_nettype none

module pushbutton_dimmer_tracker import pbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pbd_in_if.sink    i_in,
    pbd_out_if.source o_res,
    pbd_cfg_if.sink   i_cfg
);

    t_cfg cfg;
    logic mid_valid;
    logic mid_ready;
    t_mid mid;

    pbd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .i_mid_ready (mid_ready),
        .o_mid_valid (mid_valid),
        .o_mid       (mid)
    );

    pbd_level u_level (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_mid_ready (mid_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

@@ rtl/pbd_checker.sv @@
// Port-level checks of the tracker's results, bound to the top level.
`default_nettype none

module pbd_checker import pbd_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               i_ready,
    input wire logic [KIND_W-1:0]  i_kind,
    input wire logic               i_lamp_on,
    input wire logic               i_dim_up,
    input wire logic [LEVEL_W-1:0] i_shown
);

    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");

    a_none_shows_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_kind == KIND_NONE)) |-> (i_shown == '0))
        else $error("empty report carries a level");

    a_off_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_kind == KIND_RELEASE) && !i_lamp_on) |-> (i_shown == '0))
        else $error("release to off carries a level");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable({i_kind, i_lamp_on, i_dim_up, i_shown})))
        else $error("stalled result changed");

endmodule

bind pushbutton_dimmer_tracker pbd_checker u_pbd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_kind    (o_res.report_kind),
    .i_lamp_on (o_res.lamp_on),
    .i_dim_up  (o_res.dim_up),
    .i_shown   (o_res.shown_level)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench of the pushbutton dimmer tracker: directed presses, then random ones.
`default_nettype none

module tb_top;
    import pbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_kind              kind;
        logic               lamp_on;
        logic               dim_up;
        logic [LEVEL_W-1:0] shown;
    } t_report;

    typedef struct packed {
        logic              btn;
        logic [TIME_W-1:0] t;
        logic              typed;
        t_report           want;
    } t_row;

    localparam t_row DIRECTED [26] = '{
        '{1'b0, 32'd0,          1'b1, '{KIND_NONE,    1'b0, 1'b1, 16'd0}},
        '{1'b1, 32'd100,        1'b1, '{KIND_NONE,    1'b0, 1'b1, 16'd0}},
        '{1'b1, 32'd500,        1'b1, '{KIND_HELD,    1'b0, 1'b1, 16'd0}},
        '{1'b0, 32'd600,        1'b1, '{KIND_RELEASE, 1'b1, 1'b1, 16'd0}},
        '{1'b1, 32'd1000,       1'b1, '{KIND_NONE,    1'b1, 1'b1, 16'd0}},
        '{1'b1, 32'd1900,       1'b1, '{KIND_HELD,    1'b1, 1'b1, 16'd0}},
        '{1'b0, 32'd1900,       1'b1, '{KIND_RELEASE, 1'b0, 1'b1, 16'd0}},
        '{1'b1, 32'd2000,       1'b1, '{KIND_NONE,    1'b0, 1'b1, 16'd0}},
        '{1'b0, 32'd2900,       1'b1, '{KIND_RELEASE, 1'b1, 1'b1, 16'd0}},
        '{1'b1, 32'd3000,       1'b1, '{KIND_NONE,    1'b1, 1'b1, 16'd0}},
        '{1'b1, 32'd13900,      1'b1, '{KIND_HELD,    1'b1, 1'b1, 16'hFFFF}},
        '{1'b0, 32'd13900,      1'b1, '{KIND_RELEASE, 1'b1, 1'b0, 16'hFFFF}},
        '{1'b1, 32'd14000,      1'b1, '{KIND_NONE,    1'b1, 1'b0, 16'd0}},
        '{1'b1, 32'd15900,      1'b0, '{KIND_NONE,    1'b0, 1'b0, 16'd0}},
        '{1'b0, 32'd16900,      1'b0, '{KIND_NONE,    1'b0, 1'b0, 16'd0}},
        '{1'b1, 32'd17000,      1'b1, '{KIND_NONE,    1'b1, 1'b1, 16'd0}},
        '{1'b0, 32'd17100,      1'b1, '{KIND_RELEASE, 1'b0, 1'b1, 16'd0}},
        '{1'b1, 32'hFFFF_FF00,  1'b1, '{KIND_NONE,    1'b0, 1'b1, 16'd0}},
        '{1'b1, 32'h0000_0100,  1'b0, '{KIND_NONE,    1'b0, 1'b0, 16'd0}},
        '{1'b0, 32'h0000_0400,  1'b0, '{KIND_NONE,    1'b0, 1'b0, 16'd0}},
        '{1'b1, 32'd0,          1'b1, '{KIND_NONE,    1'b1, 1'b1, 16'd0}},
        '{1'b0, 32'hFFFF_FFFF,  1'b1, '{KIND_RELEASE, 1'b1, 1'b0, 16'hFFFF}},
        '{1'b1, 32'd0,          1'b1, '{KIND_NONE,    1'b1, 1'b0, 16'd0}},
        '{1'b1, 32'hFFFF_FFFF,  1'b1, '{KIND_HELD,    1'b1, 1'b0, 16'd0}},
        '{1'b0, 32'hFFFF_FFFF,  1'b1, '{KIND_RELEASE, 1'b1, 1'b1, 16'd0}},
        '{1'b0, 32'd5,          1'b1, '{KIND_NONE,    1'b1, 1'b1, 16'd0}}
    };

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic res_ready = 1'b0;
    logic calm      = 1'b0;

    int err_count   = 0;
    int cycle_count = 0;

    logic [SPEED_W-1:0]  cfg_speed = DIM_SPEED_RESET;
    logic [THRESH_W-1:0] cfg_ton   = THRESH_RESET;
    logic [THRESH_W-1:0] cfg_toff  = THRESH_RESET;

    logic               lamp_st  = 1'b0;
    logic [LEVEL_W-1:0] lvl_st   = '0;
    logic               up_st    = 1'b1;
    logic               btn_prev = 1'b0;
    logic [TIME_W-1:0]  press_t0 = '0;
    logic [TIME_W-1:0]  clock_ms = 32'd100;

    t_report expected_reports [$];

    pbd_in_if  in_if ();
    pbd_out_if res_if ();
    pbd_cfg_if cfg_if ();

    assign res_if.ready = res_ready;

    pushbutton_dimmer_tracker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [LEVEL_W-1:0] dimmed_level(input logic [TIME_W-1:0] dur);
        logic [TIME_W-1:0] thr;
        logic [63:0]       delta;
        logic [63:0]       sum;
        thr = lamp_st ? TIME_W'(cfg_ton) : TIME_W'(cfg_toff);
        if (dur < thr) return lvl_st;
        delta = (64'(cfg_speed) * 64'(dur - thr)) / MS_PER_S;
        if (up_st) begin
            sum = 64'(lvl_st) + delta;
            return (sum > 64'(LEVEL_MAX)) ? LEVEL_MAX : sum[LEVEL_W-1:0];
        end
        if (delta >= 64'(lvl_st)) return '0;
        return lvl_st - delta[LEVEL_W-1:0];
    endfunction

    function automatic t_report step_tracker(input logic btn, input logic [TIME_W-1:0] now);
        t_report           r;
        logic [TIME_W-1:0] dur;
        r = '0;
        r.kind = KIND_NONE;
        dur = now - press_t0;
        if (!btn && btn_prev) begin
            if (!lamp_st) begin
                up_st = 1'b1;
                if (dur > TIME_W'(cfg_toff)) lvl_st = dimmed_level(dur);
                lamp_st = 1'b1;
            end else if (dur > TIME_W'(cfg_ton)) begin
                lvl_st = dimmed_level(dur);
                up_st = !up_st;
            end else begin
                lamp_st = 1'b0;
            end
            r.kind = KIND_RELEASE;
            r.shown = lamp_st ? lvl_st : '0;
        end else if (btn && !btn_prev) begin
            press_t0 = now;
        end else if (btn) begin
            r.kind = KIND_HELD;
            r.shown = dimmed_level(dur);
        end
        btn_prev = btn;
        r.lamp_on = lamp_st;
        r.dim_up = up_st;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic send_sample(input logic btn, input logic [TIME_W-1:0] t,
                               input logic typed, input t_report want);
        t_report pred;
        while (!calm && $urandom_range(0, 99) < 9) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.button_level <= btn;
        in_if.time_ms      <= t;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pred = step_tracker(btn, t);
        expected_reports.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_DIM_SPEED:  cfg_speed = val[SPEED_W-1:0];
            CFG_THRESH_ON:  cfg_ton   = val[THRESH_W-1:0];
            CFG_THRESH_OFF: cfg_toff  = val[THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_reports();
        in_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_presses(input int n_items);
        int                sent;
        int                held_n;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] thr;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                clock_ms = TIME_W'($urandom);
                send_sample(1'($urandom_range(0, 1)), clock_ms, 1'b0, '0);
                sent++;
            end else begin
                repeat ($urandom_range(0, 2)) begin
                    clock_ms += TIME_W'($urandom_range(1, 40));
                    send_sample(1'b0, clock_ms, 1'b0, '0);
                    sent++;
                end
                clock_ms += TIME_W'($urandom_range(1, 40));
                start = clock_ms;
                send_sample(1'b1, start, 1'b0, '0);
                sent++;
                thr = lamp_st ? TIME_W'(cfg_ton) : TIME_W'(cfg_toff);
                case ($urandom_range(0, 5))
                    0: dur = TIME_W'($urandom_range(0, thr));
                    1: dur = thr;
                    2: dur = thr + TIME_W'($urandom_range(1, 300));
                    3: dur = thr + TIME_W'($urandom_range(0, 20000));
                    4: dur = thr + TIME_W'($urandom_range(0, 200000));
                    default: dur = TIME_W'($urandom);
                endcase
                held_n = $urandom_range(0, 3);
                for (int k = 0; k < held_n; k++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_sample(1'b1, start + thr, 1'b0, '0);
                    end else begin
                        send_sample(1'b1, start + TIME_W'($urandom_range(0, dur)), 1'b0, '0);
                    end
                    sent++;
                end
                clock_ms = start + dur;
                if ($urandom_range(0, 19) != 0) begin
                    send_sample(1'b0, clock_ms, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [SPEED_W-1:0]  sp;
        logic [THRESH_W-1:0] ton;
        logic [THRESH_W-1:0] toff;
        in_if.valid        <= 1'b0;
        in_if.button_level <= 1'b0;
        in_if.time_ms      <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_DIM_SPEED;
        cfg_if.data        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            send_sample(DIRECTED[i].btn, DIRECTED[i].t, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                drain_reports();
                case (ph)
                    1: begin sp = '1;  ton = '0;  toff = '0;  end
                    2: begin sp = '0;  ton = '1;  toff = '1;  end
                    3: begin sp = DIM_SPEED_RESET; ton = THRESH_RESET; toff = THRESH_RESET; end
                    4: begin
                        sp   = SPEED_W'($urandom_range(0, 1048575));
                        ton  = THRESH_W'($urandom_range(0, 3000));
                        toff = THRESH_W'($urandom_range(0, 3000));
                    end
                    5: begin
                        sp   = SPEED_W'($urandom_range(1, 5000));
                        ton  = THRESH_W'($urandom_range(0, 1500));
                        toff = THRESH_W'($urandom_range(0, 1500));
                    end
                    6: begin sp = '1;  ton = '1;  toff = '0;  end
                    default: begin
                        sp   = SPEED_W'($urandom);
                        ton  = THRESH_W'($urandom);
                        toff = THRESH_W'($urandom);
                    end
                endcase
                write_reg(CFG_DIM_SPEED, sp);
                write_reg(CFG_THRESH_ON, {4'($urandom), ton});
                write_reg(CFG_THRESH_OFF, {4'($urandom), toff});
                if (ph == 4) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
                cfg_if.valid <= 1'b0;
            end
            calm = (ph == 3);
            if (ph == 5) begin
                random_presses(120);
                drain_reports();
                random_presses(115);
            end else begin
                random_presses(235);
            end
        end

        drain_reports();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_report want;
        cycle_count++;
        res_ready <= calm || ($urandom_range(0, 99) >= 9);
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_reports.size() == 0) begin
                flag_error("result arrived with no request outstanding");
            end else begin
                want = expected_reports.pop_front();
                if (res_if.report_kind !== want.kind) begin
                    flag_error($sformatf("report_kind got %0d want %0d",
                                         res_if.report_kind, want.kind));
                end
                if (res_if.lamp_on !== want.lamp_on) begin
                    flag_error($sformatf("lamp_on got %0b want %0b",
                                         res_if.lamp_on, want.lamp_on));
                end
                if (res_if.dim_up !== want.dim_up) begin
                    flag_error($sformatf("dim_up got %0b want %0b",
                                         res_if.dim_up, want.dim_up));
                end
                if (res_if.shown_level !== want.shown) begin
                    flag_error($sformatf("shown_level got %0d want %0d",
                                         res_if.shown_level, want.shown));
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ pushbutton_dimmer_tracker.f @@
rtl/pbd_pkg.sv
rtl/pbd_ifs.sv
rtl/pbd_cfg_regs.sv
rtl/pbd_ctrl.sv
rtl/pbd_level.sv
rtl/pushbutton_dimmer_tracker.sv
rtl/pbd_checker.sv
dv/tb_top.sv
